@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the RTL file triac_phase_fire_timer.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_NEXT(lbl, clk, rstn, trig, cons, msg)

`endif

`endif

@@ hdl/tpft_pkg.sv @@
// ---------------------------------------------------------------------------
// tpft_pkg
// Types and constants of the TRIAC phase-angle firing timer.
// ---------------------------------------------------------------------------
package tpft_pkg;

  localparam int unsigned DelayW    = 16;
  localparam int unsigned StrengthW = 17;
  localparam int unsigned RatioW    = 13;
  localparam int unsigned FracW     = 12;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [RatioW-1:0] FULL_STRENGTH = RatioW'(4096);

  typedef logic [DelayW-1:0] delay_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ZERO_X   = 2'd1,
    OP_STRENGTH = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIRECTION   = 2'd0,
    REG_MAX_DELAY   = 2'd1,
    REG_MIN_DELAY   = 2'd2,
    REG_PULSE_WIDTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DELAY = 3'b010,
    PH_PULSE = 3'b100
  } phase_t;

  localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_CODE_DELAY = 2'd1;
  localparam logic [1:0] PHASE_CODE_PULSE = 2'd2;

  localparam delay_t RST_MAX_DELAY   = 16'd60000;
  localparam delay_t RST_MIN_DELAY   = 16'd500;
  localparam delay_t RST_PULSE_WIDTH = 16'd100;

endpackage

@@ hdl/triac_phase_fire_timer.sv @@
// ---------------------------------------------------------------------------
// triac_phase_fire_timer
// Phase-angle TRIAC firing timer driven by tick, zero-cross and strength items.
// ---------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser: opcode, tdata: strength
//  out_    | master    | tdata: forward_gate, reverse_gate, phase, current_delay
//  cfg_    | write     | index 0 direction, 1 max_delay, 2 min_delay, 3 pulse_width
//
//  One transaction is accepted every cycle unless the output stalls; each result
//  passes through the input register, loaded at the accepting edge, and then the
//  result register. The path between them holds one 16x13 multiply, a subtract and
//  the counter compare.
//  Reset is synchronous: the timer returns to idle, gates off, delay zero.
//  A stalled output holds its result while the input register keeps one more
//  transaction; in_tready drops only when both are full.
//
module triac_phase_fire_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tpft_pkg::InDataW-1:0]    in_tdata,   // [16:0] strength (signed)
  input  logic [1:0]                      in_tuser,   // [1:0] opcode
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpft_pkg::OutDataW-1:0]   out_tdata,  // [0] forward_gate,
                                                      // [1] reverse_gate,
                                                      // [3:2] phase,
                                                      // [19:4] current_delay
  // configuration port
  input  logic                            cfg_we,
  input  logic [tpft_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tpft_pkg::DelayW-1:0]     cfg_wdata
);

  import tpft_pkg::*;

  `include "assert_macros.svh"

  // configuration registers
  logic   direction_r;
  delay_t max_delay_r;
  delay_t min_delay_r;
  delay_t pulse_width_r;

  // timer state
  phase_t phase_r,      phase_nxt;
  delay_t tick_count_r, tick_count_nxt;
  delay_t period_end_r, period_end_nxt;
  delay_t fire_delay_r, fire_delay_nxt;
  logic   fwd_r,        fwd_nxt;
  logic   rev_r,        rev_nxt;

  // input register
  logic                 stage_valid_r;
  opcode_t              op_r;
  logic [StrengthW-1:0] strength_r;

  // result register
  logic                 out_valid_r;
  logic [OutDataW-1:0]  out_data_r;

  logic                 advance;
  logic                 out_free;

  logic [RatioW-1:0]        ratio;
  delay_t                   span;
  logic [DelayW+RatioW-1:0] product;
  delay_t                   new_delay;
  delay_t                   clamped_delay;
  logic [1:0]               phase_code;

  // Handshake: the result register frees up when empty or being drained,
  // and the input register moves on whenever the result register is free.
  assign out_free   = !out_valid_r || out_tready;
  assign advance    = stage_valid_r && out_free;
  assign in_tready  = !stage_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes land directly; user writes only while idle, unenforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= 1'b0;
      max_delay_r   <= RST_MAX_DELAY;
      min_delay_r   <= RST_MIN_DELAY;
      pulse_width_r <= RST_PULSE_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIRECTION:   direction_r   <= cfg_wdata[0];
        REG_MAX_DELAY:   max_delay_r   <= cfg_wdata;
        REG_MIN_DELAY:   min_delay_r   <= cfg_wdata;
        REG_PULSE_WIDTH: pulse_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Strength to delay: clamp strength, scale the span, subtract from max.
  always_comb begin
    if (strength_r[StrengthW-1]) begin
      ratio = '0;                       // negative strength
    end else if (strength_r[StrengthW-2:0] > DelayW'(FULL_STRENGTH)) begin
      ratio = FULL_STRENGTH;
    end else begin
      ratio = strength_r[RatioW-1:0];
    end
    span      = (max_delay_r >= min_delay_r) ? (max_delay_r - min_delay_r) : '0;
    product   = (DelayW+RatioW)'(span) * (DelayW+RatioW)'(ratio);
    new_delay = max_delay_r - product[FracW +: DelayW];
  end

  // Clamp the stored delay for a new period; the upper bound wins.
  always_comb begin
    if (fire_delay_r > max_delay_r) begin
      clamped_delay = max_delay_r;
    end else if (fire_delay_r < min_delay_r) begin
      clamped_delay = min_delay_r;
    end else begin
      clamped_delay = fire_delay_r;
    end
  end

  // Next timer state for the transaction held in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    period_end_nxt = period_end_r;
    fire_delay_nxt = fire_delay_r;
    fwd_nxt        = fwd_r;
    rev_nxt        = rev_r;
    case (op_r)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (tick_count_r != period_end_r) begin
            tick_count_nxt = tick_count_r + DelayW'(1);
          end else begin
            tick_count_nxt = '0;
            if (phase_r == PH_DELAY) begin
              // delay expired: sample direction and pulse width, fire
              fwd_nxt        = !direction_r;
              rev_nxt        = direction_r;
              period_end_nxt = pulse_width_r;
              phase_nxt      = PH_PULSE;
            end else begin
              fwd_nxt        = 1'b0;
              rev_nxt        = 1'b0;
              period_end_nxt = '0;
              phase_nxt      = PH_IDLE;
            end
          end
        end
      end
      OP_ZERO_X: begin
        // drop both gates and restart the delay phase
        fwd_nxt        = 1'b0;
        rev_nxt        = 1'b0;
        tick_count_nxt = '0;
        period_end_nxt = clamped_delay;
        phase_nxt      = PH_DELAY;
      end
      OP_STRENGTH: begin
        fire_delay_nxt = new_delay;
      end
      default: ;                        // unused opcode: hold everything
    endcase
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE:  phase_code = PHASE_CODE_IDLE;
      PH_DELAY: phase_code = PHASE_CODE_DELAY;
      PH_PULSE: phase_code = PHASE_CODE_PULSE;
      default:  phase_code = PHASE_CODE_IDLE;
    endcase
  end

  // Control state and valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      period_end_r  <= '0;
      fire_delay_r  <= '0;
      fwd_r         <= 1'b0;
      rev_r         <= 1'b0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_tready) begin
        stage_valid_r <= in_tvalid;
      end
      if (advance) begin
        phase_r      <= phase_nxt;
        tick_count_r <= tick_count_nxt;
        period_end_r <= period_end_nxt;
        fire_delay_r <= fire_delay_nxt;
        fwd_r        <= fwd_nxt;
        rev_r        <= rev_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Payload registers: capture on acceptance, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r       <= opcode_t'(in_tuser);
      strength_r <= in_tdata[StrengthW-1:0];
    end
    if (advance) begin
      out_data_r <= {{(OutDataW-DelayW-4){1'b0}}, fire_delay_nxt, phase_code,
                     rev_nxt, fwd_nxt};
    end
  end

  `ASSERT_ALWAYS(a_gates_exclusive, clk, rst_n, !(fwd_r && rev_r), "both gates on")
  `ASSERT_ALWAYS(a_gate_in_pulse, clk, rst_n,
                 ((phase_r == PH_PULSE) == (fwd_r || rev_r)),
                 "gate level does not match pulse phase")
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, (tick_count_r <= period_end_r),
                 "tick count ran past period end")
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, advance, out_valid_r,
               "advanced transaction left no result")

endmodule

@@ tb/sv/triac_phase_fire_timer_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// triac_phase_fire_timer_tb
// Self-checking bench for the phase-angle TRIAC firing timer. A local model
// tracks the firing state per accepted transaction; every result is compared
// field by field in order. Directed checks cover reset state, strength
// clamping, a full firing cycle with restart and reversed delay bounds;
// random phases then mix well-formed half cycles with noise, most under stalls.
// ---------------------------------------------------------------------------
module triac_phase_fire_timer_tb;
  import tpft_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned PHASE_ITEMS  = 90;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned STEADY_PHASE = 4;

  // One expected result transaction.
  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [1:0] phase;
    delay_t     delay;
  } gate_status_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [InDataW-1:0]    in_tdata   = '0;
  logic [1:0]            in_tuser   = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OutDataW-1:0]   out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index  = REG_DIRECTION;
  logic [DelayW-1:0]     cfg_wdata  = '0;

  gate_status_t expected_status[$];
  gate_status_t want;
  int unsigned  mismatches  = 0;
  int unsigned  cycle_count = 0;
  bit           steady      = 1'b0;   // suppress all idling when set

  // Local copy of registers and timer state.
  logic       m_dir        = 1'b0;
  delay_t     m_max        = RST_MAX_DELAY;
  delay_t     m_min        = RST_MIN_DELAY;
  delay_t     m_pw         = RST_PULSE_WIDTH;
  logic [1:0] m_phase      = PHASE_CODE_IDLE;
  delay_t     m_count      = '0;
  delay_t     m_end        = '0;
  delay_t     m_fire_delay = '0;
  logic [1:0] m_gates      = 2'b00;  // bit 0 forward, bit 1 reverse

  triac_phase_fire_timer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the local timer by one transaction and return the gate status.
  function automatic gate_status_t advance_timer(opcode_t op, logic [16:0] strength);
    gate_status_t     res;
    int unsigned      ratio;
    int unsigned      span;
    delay_t           bounded;
    case (op)
      OP_TICK: begin
        if (m_phase == PHASE_CODE_DELAY || m_phase == PHASE_CODE_PULSE) begin
          if (m_count != m_end) begin
            m_count = m_count + 1'b1;
          end else begin
            m_count = '0;
            if (m_phase == PHASE_CODE_DELAY) begin
              m_gates = m_dir ? 2'b10 : 2'b01;
              m_end   = m_pw;
              m_phase = PHASE_CODE_PULSE;
            end else begin
              m_gates = 2'b00;
              m_end   = '0;
              m_phase = PHASE_CODE_IDLE;
            end
          end
        end
      end
      OP_ZERO_X: begin
        // Clamp tests the upper bound first; with min above max only a delay
        // above max stays at max, anything else goes to min.
        if (m_fire_delay > m_max)      bounded = m_max;
        else if (m_fire_delay < m_min) bounded = m_min;
        else                           bounded = m_fire_delay;
        m_gates = 2'b00;
        m_count = '0;
        m_end   = bounded;
        m_phase = PHASE_CODE_DELAY;
      end
      OP_STRENGTH: begin
        if (strength[16])                  ratio = 0;
        else if (strength[15:0] > 16'd4096) ratio = 4096;
        else                               ratio = 32'(strength[15:0]);
        span = (m_max >= m_min) ? 32'(m_max - m_min) : 0;
        m_fire_delay = DelayW'(m_max - (span * ratio) / 4096);
      end
      default: begin
      end
    endcase
    res.fwd   = m_gates[0];
    res.rev   = m_gates[1];
    res.phase = m_phase;
    res.delay = m_fire_delay;
    return res;
  endfunction

  // Drive one transaction, hold it until accepted, then log the expected result.
  // Valid stays high afterwards so back-to-back items need no re-raise.
  task automatic send_item(opcode_t op, logic [16:0] strength);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(InDataW-17){1'b0}}, strength};
    do @(posedge clk); while (!in_tready);
    expected_status.push_back(advance_timer(op, strength));
  endtask

  // Drop valid, let the block drain, then write all four registers.
  task automatic apply_config(logic dir, delay_t max_d, delay_t min_d, delay_t pw);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIRECTION;
    cfg_wdata <= {{(DelayW-1){1'b0}}, dir};
    @(posedge clk);
    cfg_index <= REG_MAX_DELAY;
    cfg_wdata <= max_d;
    @(posedge clk);
    cfg_index <= REG_MIN_DELAY;
    cfg_wdata <= min_d;
    @(posedge clk);
    cfg_index <= REG_PULSE_WIDTH;
    cfg_wdata <= pw;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_dir = dir;
    m_max = max_d;
    m_min = min_d;
    m_pw  = pw;
  endtask

  // Bias strength toward the clamp edges while still covering all 17 bits.
  function automatic logic [16:0] pick_strength();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd4096;
      2:       return 17'($urandom_range(4097, 65535));
      3:       return 17'h10000 | 17'($urandom_range(0, 65535));
      4:       return 17'($urandom);
      default: return 17'($urandom_range(0, 4096));
    endcase
  endfunction

  // Reset defaults: idle tick, unused opcode, zero cross with delay zero
  // clamped up to the default minimum.
  task automatic test_reset_state();
    send_item(OP_TICK, 17'h1FFFF);
    send_item(OP_NONE, 17'h0ABCD);
    send_item(OP_ZERO_X, 17'd0);
    send_item(OP_TICK, 17'd0);
  endtask

  // Strength clamping at both ends, including negative values.
  task automatic test_strength_clamp();
    apply_config(1'b0, 16'd4, 16'd1, 16'd1);
    send_item(OP_STRENGTH, 17'd0);
    send_item(OP_STRENGTH, 17'd4097);
    send_item(OP_STRENGTH, 17'h0FFFF);
    send_item(OP_STRENGTH, 17'h10000);
    send_item(OP_STRENGTH, 17'h1FFFF);
    send_item(OP_STRENGTH, 17'd2048);
    send_item(OP_STRENGTH, 17'd4096);
  endtask

  // Full forward firing cycle, a new strength while firing, and a restart
  // by zero cross during the gate pulse.
  task automatic test_fire_cycle();
    send_item(OP_ZERO_X, 17'd0);
    repeat (2) send_item(OP_TICK, 17'd0);
    send_item(OP_STRENGTH, 17'd2048);
    send_item(OP_ZERO_X, 17'd0);
    repeat (6) send_item(OP_TICK, 17'd0);
    send_item(OP_TICK, 17'd0);
  endtask

  // Reverse gate with min above max: delay falls back to max, clamp to min.
  task automatic test_direction_and_bounds();
    apply_config(1'b1, 16'd1, 16'd3, 16'd0);
    send_item(OP_STRENGTH, 17'd1234);
    send_item(OP_ZERO_X, 17'd0);
    repeat (5) send_item(OP_TICK, 17'd0);
  endtask

  // One random phase: pick a setting, then mostly well-formed half cycles
  // (optional strength, zero cross, a run of ticks) plus raw noise.
  task automatic test_random_phase(int unsigned kind);
    int unsigned sent;
    int unsigned ticks;
    case (kind)
      0:       apply_config(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
      1:       apply_config(1'b0, 16'd0, 16'd0, 16'd0);
      2:       apply_config(1'b1, 16'd0, 16'hFFFF, 16'd0);
      default: apply_config(1'($urandom), 16'($urandom_range(0, 24)),
                            16'($urandom_range(0, 24)), 16'($urandom_range(0, 15)));
    endcase
    steady = (kind == STEADY_PHASE);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 1)) begin
          send_item(OP_STRENGTH, pick_strength());
          sent++;
        end
        send_item(OP_ZERO_X, 17'($urandom));
        sent++;
        ticks = $urandom_range(0, 48);
        repeat (ticks) begin
          // Break the run now and then with a restart or a new strength.
          case ($urandom_range(0, 99))
            0, 1:    send_item(OP_ZERO_X, 17'($urandom));
            2, 3:    send_item(OP_STRENGTH, pick_strength());
            default: send_item(OP_TICK, 17'($urandom));
          endcase
          sent++;
        end
      end else begin
        send_item(opcode_t'($urandom_range(0, 3)), 17'($urandom));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Stall the result side at random, except during the steady phase.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result transaction: tdata=%h", out_tdata);
      end else begin
        want = expected_status.pop_front();
        if (out_tdata[0] !== want.fwd || out_tdata[1] !== want.rev ||
            out_tdata[3:2] !== want.phase || out_tdata[19:4] !== want.delay) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: fwd %b/%b rev %b/%b phase %0d/%0d delay %0d/%0d (exp/act)",
                     want.fwd, out_tdata[0], want.rev, out_tdata[1],
                     want.phase, out_tdata[3:2], want.delay, out_tdata[19:4]);
        end
      end
    end
  end

  // Bound the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_strength_clamp();
    test_fire_cycle();
    test_direction_and_bounds();
    for (int unsigned k = 0; k < NUM_PHASES; k++)
      test_random_phase(k);

    // Drain: drop valid, wait for every result, then let the bench settle.
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
